/* sv/sdes_pkg.sv */
// Shared constants, types and S-DES bit functions for the byte cipher unit.
package sdes_pkg;

   // Number of full cipher passes applied to each byte.
   localparam int REPEATS = 10;

   localparam int BYTE_WIDTH = 8;
   localparam int KEY_WIDTH  = 10;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [KEY_WIDTH-1:0]  key_type;
   typedef logic [3:0]            pos_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_CIPHER_KEY   = 1'b0,
      CSR_DECRYPT_MODE = 1'b1
   } csr_index_type;

   // Subkeys in the order the two rounds of a pass use them.
   typedef struct packed {
      byte_type first;
      byte_type second;
   } subkey_type;

   // Permutation tables: entry is a 1-based position, position 1 is the MSB.
   localparam pos_type TAB_IP  [8]  = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
   localparam pos_type TAB_IIP [8]  = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
   localparam pos_type TAB_EP  [8]  = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
   localparam pos_type TAB_P4  [4]  = '{4'd2, 4'd4, 4'd3, 4'd1};
   localparam pos_type TAB_P10 [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                        4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
   localparam pos_type TAB_P8  [8]  = '{4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};

   // S-boxes, flattened as row * 4 + column.
   localparam logic [1:0] BOX_A [16] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                         2'd3, 2'd2, 2'd1, 2'd0,
                                         2'd0, 2'd2, 2'd1, 2'd3,
                                         2'd3, 2'd1, 2'd3, 2'd2};
   localparam logic [1:0] BOX_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                         2'd2, 2'd0, 2'd1, 2'd3,
                                         2'd3, 2'd0, 2'd1, 2'd0,
                                         2'd2, 2'd1, 2'd0, 2'd3};

   function automatic byte_type perm_ip(input byte_type v);
      byte_type r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8 - int'(TAB_IP[i])];
      end
      return r;
   endfunction

   function automatic byte_type perm_iip(input byte_type v);
      byte_type r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[8 - int'(TAB_IIP[i])];
      end
      return r;
   endfunction

   function automatic byte_type perm_ep(input logic [3:0] v);
      byte_type r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[4 - int'(TAB_EP[i])];
      end
      return r;
   endfunction

   function automatic logic [3:0] perm_p4(input logic [3:0] v);
      logic [3:0] r;
      for (int i = 0; i < 4; i++) begin
         r[3-i] = v[4 - int'(TAB_P4[i])];
      end
      return r;
   endfunction

   function automatic key_type perm_p10(input key_type v);
      key_type r;
      for (int i = 0; i < 10; i++) begin
         r[9-i] = v[10 - int'(TAB_P10[i])];
      end
      return r;
   endfunction

   function automatic byte_type perm_p8(input key_type v);
      byte_type r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[10 - int'(TAB_P8[i])];
      end
      return r;
   endfunction

   // Row from the outer bits, column from the inner bits.
   function automatic logic [1:0] sbox_a(input logic [3:0] x);
      return BOX_A[{x[3], x[0], x[2:1]}];
   endfunction

   function automatic logic [1:0] sbox_b(input logic [3:0] x);
      return BOX_B[{x[3], x[0], x[2:1]}];
   endfunction

   // One Feistel round: mix the low nibble into the high nibble.
   function automatic byte_type round_fk(input byte_type b, input byte_type k);
      byte_type   ep;
      logic [3:0] s;
      logic [3:0] p;
      ep = perm_ep(b[3:0]) ^ k;
      s  = {sbox_a(ep[7:4]), sbox_b(ep[3:0])};
      p  = perm_p4(s);
      return {b[7:4] ^ p, b[3:0]};
   endfunction

   // Full pass: IP, fk, nibble swap, fk, inverse IP.
   function automatic byte_type cipher_pass(input byte_type b, input subkey_type k);
      byte_type t;
      t = perm_ip(b);
      t = round_fk(t, k.first);
      t = {t[3:0], t[7:4]};
      t = round_fk(t, k.second);
      return perm_iip(t);
   endfunction

   // Derive subkeys and order them for the selected direction.
   function automatic subkey_type key_schedule(input key_type key, input logic decrypt);
      key_type    p;
      key_type    rot1;
      key_type    rot3;
      byte_type   k1;
      byte_type   k2;
      subkey_type r;
      p    = perm_p10(key);
      rot1 = {p[8:5], p[9], p[3:0], p[4]};
      rot3 = {p[6:5], p[9:7], p[1:0], p[4:2]};
      k1   = perm_p8(rot1);
      k2   = perm_p8(rot3);
      r.first  = decrypt ? k2 : k1;
      r.second = decrypt ? k1 : k2;
      return r;
   endfunction

endpackage

/* sv/sdes_byte_cipher_unit.sv */
// Top level of the byte cipher: configuration registers and pass pipeline.
//
// Usage: bytes enter on the req_ channel (req_valid, req_stall, req_data_byte)
// and leave on the rsp_ channel (rsp_valid, rsp_stall, rsp_result_byte), one
// result per byte, in order. A transfer happens on a rising clock edge with
// valid high and stall low.
// The key and the encrypt/decrypt direction are written on the csr_ port
// (index 0: 10-bit key, index 1: decrypt when bit 0 is set) by the user only
// while no byte is in flight; the block itself does not enforce this. Subkeys
// come combinationally from the key and mode registers. Each of the REPEATS
// passes (10) sits in its own register stage; an accepted byte moves through
// them in order and transfers on rsp_ from the last. Unless a stalled result
// freezes the pipeline, a new byte can be accepted every cycle: one per clock.
// The critical path is one full pass (two rounds) between stage registers.
// When the receiver stalls a valid result, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears key and mode to zero.
module sdes_byte_cipher_unit
   import sdes_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // Input byte channel
   input  logic          req_valid,
   output logic          req_stall,
   input  byte_type      req_data_byte,
   // Result byte channel
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output byte_type      rsp_result_byte,
   // Configuration write port
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  key_type       csr_write_data
);

   key_type    cipher_key_ff;
   key_type    cipher_key_in;
   logic       decrypt_mode_ff;
   logic       decrypt_mode_in;
   subkey_type subkeys;
   logic       advance;

   logic [REPEATS:0] chain_valid;
   byte_type         chain_byte [REPEATS+1];
   logic [REPEATS:0] stage_valid;

   // Decode configuration writes
   always_comb begin
      cipher_key_in   = cipher_key_ff;
      decrypt_mode_in = decrypt_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CIPHER_KEY: begin
               cipher_key_in = csr_write_data;
            end
            CSR_DECRYPT_MODE: begin
               decrypt_mode_in = csr_write_data[0];
            end
            default: begin
               cipher_key_in = cipher_key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff   <= '0;
         decrypt_mode_ff <= 1'b0;
      end else begin
         cipher_key_ff   <= cipher_key_in;
         decrypt_mode_ff <= decrypt_mode_in;
      end
   end

   // Order subkeys for the selected direction
   assign subkeys = key_schedule(cipher_key_ff, decrypt_mode_ff);

   // Freeze the pipeline only when a finished result is held back
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Chain the pass stages
   assign chain_valid[0] = req_valid;
   assign chain_byte[0]  = req_data_byte;

   for (genvar g = 0; g < REPEATS; g++) begin : g_stage
      sdes_pass_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_byte   (chain_byte[g]),
         .keys      (subkeys),
         .out_valid (chain_valid[g+1]),
         .out_byte  (chain_byte[g+1])
      );
   end

   assign stage_valid     = {chain_valid[REPEATS:1], 1'b0};
   assign rsp_valid       = chain_valid[REPEATS];
   assign rsp_result_byte = chain_byte[REPEATS];

`ifndef SYNTHESIS
   // Valid bits shift one stage per advancing cycle
   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> stage_valid[REPEATS:1] == $past(chain_valid[REPEATS-1:0]))
      else $error("valid bits did not shift with the pipeline");

   // A held result freezes every stage
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid))
      else $error("pipeline moved while the result was stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> stage_valid == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule

/* sv/sdes_pass_stage.sv */
// One pipeline stage: a full S-DES pass followed by a valid/data register.
module sdes_pass_stage
   import sdes_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       in_valid,
   input  byte_type   in_byte,
   input  subkey_type keys,
   output logic       out_valid,
   output byte_type   out_byte
);

   logic     valid_ff;
   logic     valid_in;
   byte_type byte_ff;
   byte_type byte_in;

   // Run one pass on the incoming byte
   always_comb begin
      valid_in = in_valid;
      byte_in  = cipher_pass(in_byte, keys);
   end

   // Hold valid while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Hold data while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

endmodule
